/* design/whs_pkg.sv */
// Shared constants, register codes and the arctangent table for the
// waypoint heading steering block. No dependencies.
package whs_pkg;

  // CORDIC angle accumulator fraction: units of 2^-24 degree
  localparam int ACC_FRAC  = 24;
  localparam int TABLE_LEN = 24;
  // Accumulator width: holds -100 .. +360 degrees at 2^-24 degree
  localparam int Z_W       = 35;
  localparam int ANGLE_W   = 16;
  localparam int SPEED_W   = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [Z_W-1:0] Z_DEG180 = Z_W'(64'd180 << ACC_FRAC);
  localparam logic signed [Z_W-1:0] Z_DEG360 = Z_W'(64'd360 << ACC_FRAC);

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_X  = 3'd0,
    REG_TARGET_Y  = 3'd1,
    REG_FWD_SPEED = 3'd2,
    REG_TURN_SPEED = 3'd3,
    REG_FACING_TOL = 3'd4
  } cfg_reg_t;

  // atan(2^-i) in degrees, scaled by 2^24, rounded to nearest
  function automatic logic [29:0] atan_lut(input int idx);
    case (idx)
      0:  return 30'd754974720;
      1:  return 30'd445687602;
      2:  return 30'd235489088;
      3:  return 30'd119537938;
      4:  return 30'd60000934;
      5:  return 30'd30029717;
      6:  return 30'd15018523;
      7:  return 30'd7509720;
      8:  return 30'd3754917;
      9:  return 30'd1877466;
      10: return 30'd938734;
      11: return 30'd469367;
      12: return 30'd234684;
      13: return 30'd117342;
      14: return 30'd58671;
      15: return 30'd29335;
      16: return 30'd14668;
      17: return 30'd7334;
      18: return 30'd3667;
      19: return 30'd1833;
      20: return 30'd917;
      21: return 30'd458;
      22: return 30'd229;
      23: return 30'd115;
      default: return '0;
    endcase
  endfunction

  // Number of restoring subtract steps that bring a 16-bit yaw below full
  function automatic int yaw_steps(input int full);
    int k;
    k = 0;
    for (int s = 0; s < 9; s++) begin
      if ((full << k) <= 65535) k++;
    end
    return k;
  endfunction

endpackage

/* design/whs_prep.sv */
// Front cell: forms the waypoint deltas and the CORDIC start vector.
// Depends on whs_pkg.
module whs_prep import whs_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int XY_W       = 43
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [COORD_BITS-1:0] robot_x,
  input  logic signed [COORD_BITS-1:0] robot_y,
  input  logic [ANGLE_W-1:0]          robot_yaw,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [XY_W-1:0]      x_o,
  output logic signed [XY_W-1:0]      y_o,
  output logic signed [Z_W-1:0]       z_o,
  output logic                        zero_o,
  output logic [ANGLE_W-1:0]          yaw_o
);

  localparam int EXT = XY_W - ACC_FRAC - COORD_BITS - 1;

  logic                       v_r;
  logic signed [COORD_BITS:0] dx, dy, mag_x, mag_y;
  logic                       neg;

  // y-inverted deltas, exact
  assign dx    = {target_x[COORD_BITS-1], target_x} - {robot_x[COORD_BITS-1], robot_x};
  assign dy    = {robot_y[COORD_BITS-1], robot_y} - {target_y[COORD_BITS-1], target_y};
  assign neg   = dx[COORD_BITS];
  // fold the left half plane onto the right one
  assign mag_x = neg ? -dx : dx;
  assign mag_y = neg ? -dy : dy;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;

  // advance the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  // load the start vector, prescaled by 2^24
  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      x_o    <= {{EXT{mag_x[COORD_BITS]}}, mag_x, {ACC_FRAC{1'b0}}};
      y_o    <= {{EXT{mag_y[COORD_BITS]}}, mag_y, {ACC_FRAC{1'b0}}};
      z_o    <= neg ? Z_DEG180 : '0;
      zero_o <= (dx == '0) && (dy == '0);
      yaw_o  <= robot_yaw;
    end
  end

endmodule

/* design/whs_cell.sv */
// One CORDIC vectoring cell; also does one restoring step of the yaw
// reduction modulo a full turn. Depends on whs_pkg.
module whs_cell import whs_pkg::*; #(
  parameter int XY_W     = 43,
  parameter int IDX      = 0,
  parameter int YAW_STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  input  logic                   zero_i,
  input  logic [ANGLE_W-1:0]     yaw_i,
  input  logic [ANGLE_W-1:0]     yaw_red_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output logic signed [Z_W-1:0]  z_o,
  output logic                   zero_o,
  output logic [ANGLE_W-1:0]     yaw_o,
  output logic [ANGLE_W-1:0]     yaw_red_o
);

  localparam logic signed [Z_W-1:0] ATAN  = Z_W'(atan_lut(IDX));
  localparam logic [ANGLE_W-1:0]    YSTEP = ANGLE_W'(YAW_STEP);

  logic                   v_r;
  logic signed [XY_W-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_nxt;
  logic [ANGLE_W-1:0]     yaw_red_nxt;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // rotate toward the x axis by the sign of y
  always_comb begin
    if (!y_i[XY_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  // subtract this cell's multiple of a full turn if it fits
  assign yaw_red_nxt = (yaw_red_i >= YSTEP) ? yaw_red_i - YSTEP : yaw_red_i;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      x_o       <= x_nxt;
      y_o       <= y_nxt;
      z_o       <= z_nxt;
      zero_o    <= zero_i;
      yaw_o     <= yaw_i;
      yaw_red_o <= yaw_red_nxt;
    end
  end

endmodule

/* design/whs_round.sv */
// Bearing cell: wraps the accumulated angle to 0..360 degrees and rounds
// it to the output angle unit. Depends on whs_pkg.
module whs_round import whs_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int FULL            = 46080,
  parameter int BW              = 16,
  parameter int RW              = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [Z_W-1:0] z_i,
  input  logic                  zero_i,
  input  logic [ANGLE_W-1:0]    yaw_i,
  input  logic [ANGLE_W-1:0]    yaw_red_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [BW-1:0]         bearing_o,
  output logic [ANGLE_W-1:0]    yaw_o,
  output logic [ANGLE_W-1:0]    yaw_red_o
);

  localparam int                    SHIFT     = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF      = Z_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [Z_W-1:0] WRAP_HALF = Z_W'(Z_DEG360 + HALF);
  localparam logic [RW-1:0]         FULL_R    = RW'(FULL);

  logic                  v_r;
  logic signed [Z_W-1:0] sum;
  logic [RW-1:0]         r;
  logic [BW-1:0]         bearing_nxt;

  // wrap negative angles and add the rounding half in one add
  assign sum = z_i + (z_i[Z_W-1] ? WRAP_HALF : HALF);
  assign r   = RW'(sum >>> SHIFT);

  // a result of exactly a full turn reads as zero; waypoint reached is zero
  always_comb begin
    if (zero_i) begin
      bearing_nxt = '0;
    end else if (r >= FULL_R) begin
      bearing_nxt = BW'(r - FULL_R);
    end else begin
      bearing_nxt = BW'(r);
    end
  end

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      bearing_o <= bearing_nxt;
      yaw_o     <= yaw_i;
      yaw_red_o <= yaw_red_i;
    end
  end

endmodule

/* design/whs_steer.sv */
// Output cell: facing test and shorter turn selection; holds the result
// beat until it is taken. Depends on whs_pkg.
module whs_steer import whs_pkg::*; #(
  parameter int FULL = 46080,
  parameter int BW   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [BW-1:0]      bearing_i,
  input  logic [ANGLE_W-1:0] yaw_i,
  input  logic [ANGLE_W-1:0] yaw_red_i,
  input  logic [SPEED_W-1:0] forward_speed,
  input  logic [SPEED_W-1:0] turning_speed,
  input  logic [ANGLE_W-1:0] facing_tolerance,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [SPEED_W-1:0] linear_speed,
  output logic [ANGLE_W-1:0] turn_angle,
  output logic               facing,
  output logic [ANGLE_W-1:0] bearing
);

  localparam int                   DW     = ((BW > ANGLE_W) ? BW : ANGLE_W) + 2;
  localparam logic signed [DW-1:0] FULL_S = DW'(FULL);

  logic                 v_r;
  logic signed [DW-1:0] b_s, y_s, yr_s, tol_s;
  logic signed [DW-1:0] diff, adiff, left, right, left_w, right_w, turn;
  logic                 facing_nxt;

  assign b_s   = signed'(DW'(bearing_i));
  assign y_s   = signed'(DW'(yaw_i));
  assign yr_s  = signed'(DW'(yaw_red_i));
  assign tol_s = signed'(DW'(facing_tolerance));

  // plain facing test on the raw yaw, no wraparound
  assign diff       = b_s - y_s;
  assign adiff      = diff[DW-1] ? -diff : diff;
  assign facing_nxt = adiff <= tol_s;

  // left and right turn costs on the reduced yaw; ties turn right
  assign left    = b_s - yr_s;
  assign right   = yr_s - b_s;
  assign left_w  = left[DW-1] ? left + FULL_S : left;
  assign right_w = right[DW-1] ? right + FULL_S : right;
  assign turn    = facing_nxt ? '0 : ((left_w < right_w) ? left_w : -right_w);

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      linear_speed <= facing_nxt ? forward_speed : turning_speed;
      turn_angle   <= ANGLE_W'(turn);
      facing       <= facing_nxt;
      bearing      <= ANGLE_W'(bearing_i);
    end
  end

endmodule

/* design/waypoint_heading_steering.sv */
// Waypoint heading steering: takes one robot pose per beat and returns the
// bearing to the configured waypoint, a facing flag, a linear speed and a
// signed turn angle (left positive), angles in 2^-ANGLE_FRAC_BITS degree.
// The block takes one pose every cycle while the output is not stalled;
// each pose passes through the chain (front cell, one CORDIC cell per
// iteration, bearing cell, output cell), each of which registers it,
// before its result beat shows. Every cell has its own valid
// flag and stalls only when the cell after it is full, so empty slots
// close up under output backpressure. Write configuration only when no
// pose is in flight. Depends on whs_pkg and the whs_* cells.
module waypoint_heading_steering import whs_pkg::*; #(
  parameter int CORDIC_STAGES   = 16,
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pose channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_BITS-1:0] in_robot_x,
  input  logic signed [COORD_BITS-1:0] in_robot_y,
  input  logic [ANGLE_W-1:0]          in_robot_yaw,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [SPEED_W-1:0]          out_linear_speed,
  output logic signed [ANGLE_W-1:0]   out_turn_angle,
  output logic                        out_facing,
  output logic [ANGLE_W-1:0]          out_bearing,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [((COORD_BITS > 16) ? COORD_BITS : 16)-1:0] cfg_wdata
);

  localparam int NS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int XY_W   = COORD_BITS + 3 + ACC_FRAC;
  localparam int FULL   = 360 << ANGLE_FRAC_BITS;
  localparam int BW     = $clog2(FULL);
  localparam int RW     = $clog2(FULL + 1);
  localparam int YSTEPS = yaw_steps(FULL);

  // configuration registers
  logic signed [COORD_BITS-1:0] target_x_r, target_y_r;
  logic [SPEED_W-1:0]           fwd_speed_r, turn_speed_r;
  logic [ANGLE_W-1:0]           facing_tol_r;

  // chain interconnect
  logic                   v_w   [NS+1];
  logic                   rdy_w [NS+1];
  logic signed [XY_W-1:0] x_w   [NS+1];
  logic signed [XY_W-1:0] y_w   [NS+1];
  logic signed [Z_W-1:0]  z_w   [NS+1];
  logic                   zero_w [NS+1];
  logic [ANGLE_W-1:0]     yaw_w [NS+1];
  logic [ANGLE_W-1:0]     yr_w  [NS+1];

  logic                   rnd_v, rnd_rdy;
  logic [BW-1:0]          rnd_bearing;
  logic [ANGLE_W-1:0]     rnd_yaw, rnd_yr;
  logic [ANGLE_W-1:0]     turn_u;

  // decode configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r   <= '0;
      target_y_r   <= '0;
      fwd_speed_r  <= '0;
      turn_speed_r <= '0;
      facing_tol_r <= ANGLE_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TARGET_X:   target_x_r   <= cfg_wdata[COORD_BITS-1:0];
        REG_TARGET_Y:   target_y_r   <= cfg_wdata[COORD_BITS-1:0];
        REG_FWD_SPEED:  fwd_speed_r  <= cfg_wdata[SPEED_W-1:0];
        REG_TURN_SPEED: turn_speed_r <= cfg_wdata[SPEED_W-1:0];
        REG_FACING_TOL: facing_tol_r <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  whs_prep #(
    .COORD_BITS(COORD_BITS),
    .XY_W      (XY_W)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_valid),
    .ready_o  (in_ready),
    .robot_x  (in_robot_x),
    .robot_y  (in_robot_y),
    .robot_yaw(in_robot_yaw),
    .target_x (target_x_r),
    .target_y (target_y_r),
    .valid_o  (v_w[0]),
    .ready_i  (rdy_w[0]),
    .x_o      (x_w[0]),
    .y_o      (y_w[0]),
    .z_o      (z_w[0]),
    .zero_o   (zero_w[0]),
    .yaw_o    (yaw_w[0])
  );

  // yaw reduction starts from the raw yaw
  assign yr_w[0] = yaw_w[0];

  // row of CORDIC cells
  for (genvar i = 0; i < NS; i++) begin : g_cell
    whs_cell #(
      .XY_W    (XY_W),
      .IDX     (i),
      .YAW_STEP((i < YSTEPS) ? (FULL << (YSTEPS - 1 - i)) : 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_i  (v_w[i]),
      .ready_o  (rdy_w[i]),
      .x_i      (x_w[i]),
      .y_i      (y_w[i]),
      .z_i      (z_w[i]),
      .zero_i   (zero_w[i]),
      .yaw_i    (yaw_w[i]),
      .yaw_red_i(yr_w[i]),
      .valid_o  (v_w[i+1]),
      .ready_i  (rdy_w[i+1]),
      .x_o      (x_w[i+1]),
      .y_o      (y_w[i+1]),
      .z_o      (z_w[i+1]),
      .zero_o   (zero_w[i+1]),
      .yaw_o    (yaw_w[i+1]),
      .yaw_red_o(yr_w[i+1])
    );
  end

  whs_round #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .FULL           (FULL),
    .BW             (BW),
    .RW             (RW)
  ) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (v_w[NS]),
    .ready_o  (rdy_w[NS]),
    .z_i      (z_w[NS]),
    .zero_i   (zero_w[NS]),
    .yaw_i    (yaw_w[NS]),
    .yaw_red_i(yr_w[NS]),
    .valid_o  (rnd_v),
    .ready_i  (rnd_rdy),
    .bearing_o(rnd_bearing),
    .yaw_o    (rnd_yaw),
    .yaw_red_o(rnd_yr)
  );

  whs_steer #(
    .FULL(FULL),
    .BW  (BW)
  ) u_steer (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (rnd_v),
    .ready_o         (rnd_rdy),
    .bearing_i       (rnd_bearing),
    .yaw_i           (rnd_yaw),
    .yaw_red_i       (rnd_yr),
    .forward_speed   (fwd_speed_r),
    .turning_speed   (turn_speed_r),
    .facing_tolerance(facing_tol_r),
    .valid_o         (out_valid),
    .ready_i         (out_ready),
    .linear_speed    (out_linear_speed),
    .turn_angle      (turn_u),
    .facing          (out_facing),
    .bearing         (out_bearing)
  );

  assign out_turn_angle = signed'(turn_u);

`ifndef SYNTHESIS
  // facing results never carry a turn
  a_facing_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_facing |-> out_turn_angle == '0)
    else $error("facing result with nonzero turn");

  // speed follows the facing flag
  a_speed_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_linear_speed == (out_facing ? fwd_speed_r : turn_speed_r))
    else $error("linear speed does not match facing flag");

  // yaw reduction is complete at the end of the cell row
  a_yaw_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    v_w[NS] |-> 32'(yr_w[NS]) < 32'(FULL))
    else $error("yaw not reduced below a full turn");

  // bearing stays inside one turn
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_v |-> 32'(rnd_bearing) < 32'(FULL))
    else $error("bearing out of range");
`endif

endmodule
